// ===== rtl/core/csg_pkg.sv =====
// Shared types, widths and constants of the CORDIC sine sample generator.
`default_nettype none
package csg_pkg;

   localparam int AMP_W   = 16;
   localparam int PHASE_W = 24;
   localparam int SAMP_W  = 16;
   localparam int VEC_W   = 25;
   localparam int ANG_W   = 24;
   localparam int ATAN_W  = 22;
   localparam int RESID_W = 22;
   localparam int SUM_W   = 27;

   localparam int TABLE_LEN         = 22;
   localparam int DEFAULT_ITERATIONS = 20;

   localparam logic [ATAN_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
      22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
      22'd41718,   22'd20860,   22'd10430,  22'd5215,   22'd2608,   22'd1304,
      22'd652,     22'd326,     22'd163,    22'd81,     22'd41,     22'd20,
      22'd10,      22'd5,       22'd3,      22'd1
   };

   localparam logic [1:0] QUAD_0   = 2'd0;
   localparam logic [1:0] QUAD_90  = 2'd1;
   localparam logic [1:0] QUAD_180 = 2'd2;
   localparam logic [1:0] QUAD_270 = 2'd3;

   localparam logic signed [SUM_W-1:0] SAT_LIMIT = SUM_W'(8388608);
   localparam logic [SAMP_W-1:0] SAT_NEG = 16'h8001;
   localparam logic [SAMP_W-1:0] SAT_POS = 16'h7fff;

   typedef struct packed {
      logic signed [VEC_W-1:0] c;
      logic signed [VEC_W-1:0] s;
      logic signed [ANG_W-1:0] z;
   } csg_vec_type;

endpackage
`default_nettype wire

// ===== rtl/core/csg_prep.sv =====
// Input stage: amplitude widening and quadrant start vector selection.
`default_nettype none
module csg_prep
   import csg_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [AMP_W-1:0]     amplitude,
   input  wire logic [PHASE_W-1:0]   phase_angle,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output csg_vec_type               out_vec
);

   logic        valid_ff;
   csg_vec_type vec_ff;
   csg_vec_type vec_in;
   logic signed [VEC_W-1:0] a_pos;
   logic signed [VEC_W-1:0] a_neg;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

   always_comb begin
      a_pos = signed'({3'b000, amplitude, amplitude[AMP_W-1:AMP_W-6]});
      a_neg = -a_pos;
      vec_in.z = signed'({{(ANG_W-RESID_W){1'b0}}, phase_angle[RESID_W-1:0]});
      unique case (phase_angle[PHASE_W-1:PHASE_W-2])
         QUAD_0: begin
            vec_in.c = a_pos;
            vec_in.s = '0;
         end
         QUAD_90: begin
            vec_in.c = '0;
            vec_in.s = a_pos;
         end
         QUAD_180: begin
            vec_in.c = a_neg;
            vec_in.s = '0;
         end
         QUAD_270: begin
            vec_in.c = '0;
            vec_in.s = a_neg;
         end
         default: begin
            vec_in.c = '0;
            vec_in.s = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/csg_step.sv =====
// One registered CORDIC rotation step with a fixed shift and arctangent.
`default_nettype none
module csg_step
   import csg_pkg::*;
#(
   parameter int SHIFT = 0
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire csg_vec_type in_vec,
   output logic             out_valid,
   input  wire logic        out_ready,
   output csg_vec_type      out_vec
);

   localparam logic signed [ANG_W-1:0] ATAN_VAL =
      signed'({{(ANG_W-ATAN_W){1'b0}}, ATAN_TABLE[SHIFT]});

   logic        valid_ff;
   csg_vec_type vec_ff;
   csg_vec_type vec_in;
   logic signed [VEC_W-1:0] c_cur;
   logic signed [VEC_W-1:0] s_cur;
   logic signed [VEC_W-1:0] c_sh;
   logic signed [VEC_W-1:0] s_sh;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

   always_comb begin
      c_cur = in_vec.c;
      s_cur = in_vec.s;
      c_sh  = c_cur >>> SHIFT;
      s_sh  = s_cur >>> SHIFT;
      if (!in_vec.z[ANG_W-1]) begin
         vec_in.s = s_cur + c_sh;
         vec_in.c = c_cur - s_sh;
         vec_in.z = in_vec.z - ATAN_VAL;
      end else begin
         vec_in.s = s_cur - c_sh;
         vec_in.c = c_cur + s_sh;
         vec_in.z = in_vec.z + ATAN_VAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/csg_scale.sv =====
// Gain correction by shift-adds, saturation and the output register.
`default_nettype none
module csg_scale
   import csg_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic signed [VEC_W-1:0]  in_s,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [SAMP_W-1:0]             sample,
   output logic                          clipped
);

   logic                     sum_valid_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  s_ext;
   logic                     sum_ready;
   logic                     out_valid_ff;
   logic [SAMP_W-1:0]        sample_ff;
   logic [SAMP_W-1:0]        sample_in;
   logic                     clipped_ff;
   logic                     clipped_in;

   assign sum_ready = !out_valid_ff || out_ready;
   assign in_ready  = !sum_valid_ff || sum_ready;
   assign out_valid = out_valid_ff;
   assign sample    = sample_ff;
   assign clipped   = clipped_ff;

   always_comb begin
      s_ext  = SUM_W'(in_s);
      sum_in = s_ext + (s_ext >>> 3) + (s_ext >>> 4) + (s_ext >>> 6) + (s_ext >>> 7);
   end

   always_comb begin
      priority if (sum_ff <= -SAT_LIMIT) begin
         sample_in  = SAT_NEG;
         clipped_in = 1'b1;
      end else if (sum_ff >= SAT_LIMIT) begin
         sample_in  = SAT_POS;
         clipped_in = 1'b1;
      end else begin
         sample_in  = sum_ff[SAMP_W+7:8];
         clipped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            sum_valid_ff <= in_valid;
         end
         if (sum_ready) begin
            out_valid_ff <= sum_valid_ff;
         end
      end
      if (in_ready && in_valid) begin
         sum_ff <= sum_in;
      end
      if (sum_ready && sum_valid_ff) begin
         sample_ff  <= sample_in;
         clipped_ff <= clipped_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/cordic_sine_sample_generator_top.sv =====
// Top level of the pipelined CORDIC sine sample generator.
`default_nettype none
// Each beat on req carries an amplitude and a 24-bit phase and yields one
// saturated 16-bit sine sample on rsp. The block takes a new beat every clock
// cycle unless a stall on rsp has filled the pipeline; there is one register
// stage for the quadrant setup, one per CORDIC rotation, and two for gain
// correction and saturation. Each stage holds its beat while the next one is
// full, so a stall on rsp backs up the pipeline without loss, and empty stages
// still take new beats while a finished sample waits.
module cordic_sine_sample_generator_top
   import csg_pkg::*;
#(
   parameter int ITERATIONS = DEFAULT_ITERATIONS
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // amplitude[15:0], phase_angle[39:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // sample[15:0]
   output logic [0:0]       rsp_tuser   // clipped[0]
);

   localparam int NSTEPS = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
   localparam int DEPTH  = NSTEPS + 3;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic        valid [NSTEPS+1];
   logic        ready [NSTEPS+1];
   csg_vec_type vec   [NSTEPS+1];
   logic        sample_clipped;

   csg_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .amplitude   (req_tdata[AMP_W-1:0]),
      .phase_angle (req_tdata[AMP_W+PHASE_W-1:AMP_W]),
      .out_valid   (valid[0]),
      .out_ready   (ready[0]),
      .out_vec     (vec[0])
   );

   for (genvar i = 0; i < NSTEPS; i++) begin : g_step
      csg_step #(
         .SHIFT (i)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[i]),
         .in_ready  (ready[i]),
         .in_vec    (vec[i]),
         .out_valid (valid[i+1]),
         .out_ready (ready[i+1]),
         .out_vec   (vec[i+1])
      );
   end

   csg_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid[NSTEPS]),
      .in_ready  (ready[NSTEPS]),
      .in_s      (vec[NSTEPS].s),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .sample    (rsp_tdata),
      .clipped   (sample_clipped)
   );

   assign rsp_tuser[0] = sample_clipped;

   logic [CNT_W-1:0] inflight_ff;
   logic [CNT_W-1:0] inflight_in;

   always_comb begin
      inflight_in = inflight_ff + CNT_W'(req_tvalid && req_tready)
                    - CNT_W'(rsp_tvalid && rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == SAT_POS || rsp_tdata == SAT_NEG)
      else $error("Clipped beat carries a value other than a saturation limit.");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inflight_ff != '0)
      else $error("Result beat presented with no item in flight.");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(DEPTH))
      else $error("More items in flight than pipeline stages.");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      inflight_ff == CNT_W'(DEPTH) && !rsp_tready |-> !req_tready)
      else $error("Input accepted while every stage holds a beat.");

endmodule
`default_nettype wire

// ===== tb/cordic_sine_sample_generator_top_test.sv =====
// Self-checking testbench for the CORDIC sine sample generator with random stalls on both streams.
`timescale 1ns / 1ps
module cordic_sine_sample_generator_top_test
   import csg_pkg::*;
();

   localparam int STAGES = DEFAULT_ITERATIONS;
   localparam int ROTATIONS = (STAGES > TABLE_LEN) ? TABLE_LEN : STAGES;
   localparam int LONG_STALL = 300;

   typedef struct {
      logic [AMP_W-1:0]   amp;
      logic [PHASE_W-1:0] phase;
   } tone_beat_type;

   typedef struct {
      logic [SAMP_W-1:0] sample;
      logic              clipped;
   } sine_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   tone_beat_type   pending_beats[$];
   sine_result_type expected_samples[$];
   logic            req_taken = 1'b0;
   logic            idle_enabled = 1'b1;
   logic            stall_armed = 1'b0;
   logic            stall_done = 1'b0;
   int              stall_count = 0;
   int              send_gap = 0;
   int              recv_gap = 0;
   int              beats_queued = 0;
   int              beats_accepted = 0;
   int              mismatch_count = 0;

   cordic_sine_sample_generator_top #(.ITERATIONS(STAGES)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic sine_result_type predict_sine(input logic [AMP_W-1:0] amp,
                                                    input logic [PHASE_W-1:0] phase);
      logic signed [VEC_W-1:0] mag;
      logic signed [VEC_W-1:0] c;
      logic signed [VEC_W-1:0] s;
      logic signed [VEC_W-1:0] c_next;
      logic signed [VEC_W-1:0] s_next;
      logic signed [ANG_W-1:0] z;
      logic signed [SUM_W-1:0] s_wide;
      logic signed [SUM_W-1:0] r;
      sine_result_type res;
      mag = {3'b000, amp, amp[AMP_W-1:AMP_W-6]};
      case (phase[PHASE_W-1:PHASE_W-2])
         QUAD_0: begin
            c = mag;
            s = '0;
         end
         QUAD_90: begin
            c = '0;
            s = mag;
         end
         QUAD_180: begin
            c = -mag;
            s = '0;
         end
         default: begin
            c = '0;
            s = -mag;
         end
      endcase
      z = {2'b00, phase[RESID_W-1:0]};
      for (int i = 0; i < ROTATIONS; i++) begin
         if (!z[ANG_W-1]) begin
            s_next = s + (c >>> i);
            c_next = c - (s >>> i);
            z = z - ANG_W'(ATAN_TABLE[i]);
         end else begin
            s_next = s - (c >>> i);
            c_next = c + (s >>> i);
            z = z + ANG_W'(ATAN_TABLE[i]);
         end
         s = s_next;
         c = c_next;
      end
      s_wide = s;
      r = s_wide + (s_wide >>> 3) + (s_wide >>> 4) + (s_wide >>> 6) + (s_wide >>> 7);
      if (r <= -SAT_LIMIT) begin
         res.sample = SAT_NEG;
         res.clipped = 1'b1;
      end else if (r >= SAT_LIMIT) begin
         res.sample = SAT_POS;
         res.clipped = 1'b1;
      end else begin
         res.sample = SAMP_W'(r >>> 8);
         res.clipped = 1'b0;
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic queue_beat(input logic [AMP_W-1:0] amp, input logic [PHASE_W-1:0] phase);
      tone_beat_type beat;
      beat.amp = amp;
      beat.phase = phase;
      pending_beats.push_back(beat);
      beats_queued++;
   endtask

   // Sender: presents the next pending beat, holding it until it is taken.
   always @(negedge clock) begin
      tone_beat_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 11) - 1;
            req_tvalid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            beat = pending_beats.pop_front();
            req_tdata <= {beat.phase, beat.amp};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure plus one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_armed && !stall_done) begin
         if (stall_count == LONG_STALL) begin
            stall_done <= 1'b1;
            rsp_tready <= 1'b1;
         end else begin
            stall_count++;
            rsp_tready <= 1'b0;
         end
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 9) == 0) begin
         recv_gap = $urandom_range(1, 11) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sine_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            expected_samples.push_back(predict_sine(req_tdata[15:0], req_tdata[39:16]));
            beats_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               flag_mismatch($sformatf("unexpected sample beat: sample %h clipped %b",
                                       rsp_tdata, rsp_tuser[0]));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata !== want.sample)
                  flag_mismatch($sformatf("sample mismatch: expected %h, actual %h",
                                          want.sample, rsp_tdata));
               if (rsp_tuser[0] !== want.clipped)
                  flag_mismatch($sformatf("clipped mismatch: expected %b, actual %b",
                                          want.clipped, rsp_tuser[0]));
            end
         end
      end
   end

   initial begin
      logic [AMP_W-1:0]   amp_set[5];
      logic [PHASE_W-1:0] phase_set[9];
      logic [AMP_W-1:0]   amp;
      logic [PHASE_W-1:0] phase;
      amp_set = '{16'hffff, 16'h0000, 16'h0001, 16'h8000, 16'h7fff};
      phase_set = '{24'h000000, 24'h400000, 24'h800000, 24'hc00000, 24'h200000,
                    24'h3fffff, 24'hffffff, 24'h555555, 24'haaaaaa};
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (phase_set[p]) queue_beat(amp_set[0], phase_set[p]);
      foreach (amp_set[a]) queue_beat(amp_set[a], 24'h600000);
      foreach (amp_set[a]) queue_beat(amp_set[a], 24'he00000);

      for (int chunk = 0; chunk < 5; chunk++) begin
         while (pending_beats.size() != 0) @(posedge clock);
         if (chunk == 1) stall_armed = 1'b1;
         if (chunk == 4) idle_enabled = 1'b0;
         repeat (250) begin
            case ($urandom_range(0, 3))
               0: amp = 16'hffff - 16'($urandom_range(0, 255));
               1: amp = 16'($urandom_range(0, 255));
               default: amp = 16'($urandom);
            endcase
            if ($urandom_range(0, 4) == 0)
               phase = {2'($urandom), 22'($urandom_range(0, 63)) ^ {22{1'($urandom)}}};
            else
               phase = 24'($urandom);
            queue_beat(amp, phase);
         end
      end

      while (beats_accepted != beats_queued || expected_samples.size() != 0) @(posedge clock);
      repeat (STAGES + 16) @(posedge clock);
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("cordic_sine_sample_generator_top_test: PASS");
      end else begin
         $display("cordic_sine_sample_generator_top_test: FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("cordic_sine_sample_generator_top_test: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/csg_pkg.sv
rtl/core/csg_prep.sv
rtl/core/csg_step.sv
rtl/core/csg_scale.sv
rtl/core/cordic_sine_sample_generator_top.sv
tb/cordic_sine_sample_generator_top_test.sv
